[rtl/core/stok_pkg.sv]
// Shared types, token codes and character tables for the source tokenizer.
package stok_pkg;

	// Default sizes
	localparam int IDENT_MAX_LEN_D  = 255;
	localparam int NUMBER_MAX_LEN_D = 63;
	localparam int STRING_MAX_LEN_D = 1023;
	localparam int LINE_BITS_D      = 20;
	localparam int COLUMN_BITS_D    = 16;

	// Token kinds
	localparam logic [5:0] K_PLUS      = 6'd15;
	localparam logic [5:0] K_MINUS     = 6'd16;
	localparam logic [5:0] K_STAR      = 6'd17;
	localparam logic [5:0] K_SLASH     = 6'd18;
	localparam logic [5:0] K_MOD       = 6'd19;
	localparam logic [5:0] K_EQEQ      = 6'd20;
	localparam logic [5:0] K_NEQ       = 6'd21;
	localparam logic [5:0] K_LT        = 6'd22;
	localparam logic [5:0] K_GT        = 6'd23;
	localparam logic [5:0] K_LTE       = 6'd24;
	localparam logic [5:0] K_GTE       = 6'd25;
	localparam logic [5:0] K_LPAREN    = 6'd26;
	localparam logic [5:0] K_RPAREN    = 6'd27;
	localparam logic [5:0] K_LBRACE    = 6'd28;
	localparam logic [5:0] K_RBRACE    = 6'd29;
	localparam logic [5:0] K_LBRACKET  = 6'd30;
	localparam logic [5:0] K_RBRACKET  = 6'd31;
	localparam logic [5:0] K_COLON     = 6'd32;
	localparam logic [5:0] K_COMMA     = 6'd33;
	localparam logic [5:0] K_ARROW     = 6'd34;
	localparam logic [5:0] K_ASSIGN    = 6'd35;
	localparam logic [5:0] K_SEMICOLON = 6'd36;
	localparam logic [5:0] K_IDENT     = 6'd37;
	localparam logic [5:0] K_NUMBER    = 6'd38;
	localparam logic [5:0] K_STRLIT    = 6'd39;
	localparam logic [5:0] K_NEWLINE   = 6'd41;
	localparam logic [5:0] K_EOF       = 6'd42;
	localparam logic [5:0] K_ERROR     = 6'd43;
	localparam logic [5:0] K_NONE      = 6'd63;

	// Error reasons
	localparam logic [1:0] R_NONE   = 2'd0;
	localparam logic [1:0] R_UNEXP  = 2'd1;
	localparam logic [1:0] R_UNTERM = 2'd2;
	localparam logic [1:0] R_LONG   = 2'd3;

	localparam int NUM_KW = 17;
	localparam int MAX_TOK = 3;

	// Keyword spellings, right aligned, with length and kind
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'("let"), 48'("const"), 48'("func"), 48'("return"), 48'("if"),
		48'("else"), 48'("while"), 48'("for"), 48'("in"), 48'("range"),
		48'("int"), 48'("float"), 48'("bool"), 48'("string"), 48'("void"),
		48'("true"), 48'("false")
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2,
		3'd5, 3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5
	};
	localparam logic [5:0] KW_KIND [NUM_KW] = '{
		6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
		6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd40, 6'd40
	};

	typedef enum logic [2:0] {
		M_IDLE, M_HELD, M_COMMENT, M_STRING, M_NUMBER, M_NUMDOT, M_IDENT
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [19:0] first_line;
		logic [15:0] start_column;
		logic [9:0]  value_length;
		logic [1:0]  error_reason;
		logic        last_of_run;
	} tok_item_t;

	// Tokens produced by one transfer
	typedef struct packed {
		tok_item_t [MAX_TOK-1:0] toks;
		logic [1:0]              count;
	} tok_run_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "_");
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"%": k = K_MOD;
			"=": k = K_ASSIGN;
			"<": k = K_LT;
			">": k = K_GT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACKET;
			"]": k = K_RBRACKET;
			":": k = K_COLON;
			",": k = K_COMMA;
			";": k = K_SEMICOLON;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
		logic [5:0] k;
		k = K_NONE;
		if (h == "-" && c == ">") k = K_ARROW;
		else if (c == "=") begin
			if (h == "=") k = K_EQEQ;
			else if (h == "!") k = K_NEQ;
			else if (h == "<") k = K_LTE;
			else if (h == ">") k = K_GTE;
		end
		return k;
	endfunction

	// Drop keywords that do not match character c at position p
	function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] hits,
			input logic [9:0] p, input logic [7:0] c);
		logic [NUM_KW-1:0] h;
		h = hits;
		for (int k = 0; k < NUM_KW; k++) begin
			if (p >= 10'(KW_LEN[k])) h[k] = 1'b0;
			else if (c != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(p[2:0])) +: 8])
				h[k] = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [5:0] ident_kind(input logic [NUM_KW-1:0] hits,
			input logic [9:0] len);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = NUM_KW - 1; i >= 0; i--)
			if (hits[i] && len == 10'(KW_LEN[i])) k = KW_KIND[i];
		return k;
	endfunction

endpackage

[rtl/core/stok_lexer.sv]
// Scanner state and single-pass token logic for one source byte.
module stok_lexer import stok_pkg::*; #(
	parameter int IDENT_MAX_LEN  = IDENT_MAX_LEN_D,
	parameter int NUMBER_MAX_LEN = NUMBER_MAX_LEN_D,
	parameter int STRING_MAX_LEN = STRING_MAX_LEN_D,
	parameter int LINE_BITS      = LINE_BITS_D,
	parameter int COLUMN_BITS    = COLUMN_BITS_D
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  src_item_t din,
	output tok_run_t  run
);

	localparam int CSW = ((COLUMN_BITS > 10) ? COLUMN_BITS : 10) + 1;

	scan_mode_t               mode_q, nmode;
	logic [7:0]               held_q, nheld;
	logic [9:0]               cnt_q, ncnt;
	logic                     dot_q, ndot;
	logic [NUM_KW-1:0]        hits_q, nhits;
	logic [LINE_BITS-1:0]     line_q, nline, tline_q, ntline;
	logic [COLUMN_BITS-1:0]   col_q, ncol, tcol_q, ntcol;
	logic                     fin_q, nfin;
	tok_item_t [MAX_TOK-1:0]  toks;
	logic [1:0]               n;
	logic                     restart;
	logic [7:0]               c;
	logic [5:0]               k;
	logic [CSW-1:0]           dsum;
	logic [COLUMN_BITS-1:0]   dcol;

	function automatic tok_item_t mk_tok(input logic [5:0] kind,
			input logic [LINE_BITS-1:0] ln, input logic [COLUMN_BITS-1:0] cl,
			input logic [9:0] len, input logic [1:0] why);
		tok_item_t t;
		t.token_kind   = kind;
		t.first_line   = 20'(ln);
		t.start_column = 16'(cl);
		t.value_length = len;
		t.error_reason = why;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	// Column of a dot that follows a number, saturating
	always_comb begin
		dsum = CSW'(tcol_q) + CSW'(cnt_q);
		if (dsum > CSW'({COLUMN_BITS{1'b1}})) dcol = '1;
		else dcol = COLUMN_BITS'(dsum);
	end

	// Resolve the pending token, restart on the byte, advance position
	always_comb begin
		nmode   = mode_q;
		nheld   = held_q;
		ncnt    = cnt_q;
		ndot    = dot_q;
		nhits   = hits_q;
		nline   = line_q;
		ncol    = col_q;
		ntline  = tline_q;
		ntcol   = tcol_q;
		nfin    = fin_q;
		toks    = '0;
		n       = 2'd0;
		restart = 1'b0;
		k       = K_NONE;
		c       = din.char_byte;
		if (accept && !fin_q) begin
			if (din.end_of_text || c == 8'd0) begin
				case (mode_q)
					M_HELD: begin
						k = single_kind(held_q);
						toks[n] = mk_tok(k, tline_q, tcol_q, 10'd1,
							(k == K_ERROR) ? R_UNEXP : R_NONE);
						n = n + 2'd1;
					end
					M_STRING: begin
						toks[n] = mk_tok(K_ERROR, tline_q, tcol_q, 10'd0, R_UNTERM);
						n = n + 2'd1;
					end
					M_NUMBER: begin
						toks[n] = mk_tok(K_NUMBER, tline_q, tcol_q, cnt_q, R_NONE);
						n = n + 2'd1;
					end
					M_NUMDOT: begin
						toks[n] = mk_tok(K_NUMBER, tline_q, tcol_q, cnt_q, R_NONE);
						n = n + 2'd1;
						toks[n] = mk_tok(K_ERROR, tline_q, dcol, 10'd1, R_UNEXP);
						n = n + 2'd1;
					end
					M_IDENT: begin
						toks[n] = mk_tok(ident_kind(hits_q, cnt_q), tline_q, tcol_q,
							cnt_q, R_NONE);
						n = n + 2'd1;
					end
					default: ;
				endcase
				nmode = M_IDLE;
				toks[n] = mk_tok(K_EOF, line_q, col_q, 10'd0, R_NONE);
				n = n + 2'd1;
				nfin = 1'b1;
			end else begin
				case (mode_q)
					M_HELD: begin
						nmode = M_IDLE;
						k = pair_kind(held_q, c);
						if (held_q == "/" && c == "/") nmode = M_COMMENT;
						else if (k != K_NONE) begin
							toks[n] = mk_tok(k, tline_q, tcol_q, 10'd2, R_NONE);
							n = n + 2'd1;
						end else begin
							k = single_kind(held_q);
							toks[n] = mk_tok(k, tline_q, tcol_q, 10'd1,
								(k == K_ERROR) ? R_UNEXP : R_NONE);
							n = n + 2'd1;
							restart = 1'b1;
						end
					end
					M_COMMENT: begin
						if (c == 8'h0A) begin
							nmode = M_IDLE;
							restart = 1'b1;
						end
					end
					M_STRING: begin
						if (c == "\"") begin
							toks[n] = mk_tok(K_STRLIT, tline_q, tcol_q, cnt_q, R_NONE);
							n = n + 2'd1;
							nmode = M_IDLE;
						end else if (cnt_q >= 10'(STRING_MAX_LEN)) begin
							toks[n] = mk_tok(K_ERROR, tline_q, tcol_q, 10'd0, R_LONG);
							n = n + 2'd1;
							nmode = M_IDLE;
							restart = 1'b1;
						end else begin
							ncnt = cnt_q + 10'd1;
						end
					end
					M_NUMBER: begin
						if (is_digit(c) && cnt_q < 10'(NUMBER_MAX_LEN)) begin
							ncnt = cnt_q + 10'd1;
						end else if (c == "." && !dot_q && cnt_q < 10'(NUMBER_MAX_LEN)) begin
							nmode = M_NUMDOT;
						end else begin
							toks[n] = mk_tok(K_NUMBER, tline_q, tcol_q, cnt_q, R_NONE);
							n = n + 2'd1;
							nmode = M_IDLE;
							restart = 1'b1;
						end
					end
					M_NUMDOT: begin
						if (is_digit(c)) begin
							ndot  = 1'b1;
							nmode = M_NUMBER;
							if (cnt_q + 10'd1 >= 10'(NUMBER_MAX_LEN)) begin
								toks[n] = mk_tok(K_NUMBER, tline_q, tcol_q, cnt_q + 10'd1,
									R_NONE);
								n = n + 2'd1;
								ncnt = cnt_q + 10'd1;
								nmode = M_IDLE;
								restart = 1'b1;
							end else begin
								ncnt = cnt_q + 10'd2;
							end
						end else begin
							toks[n] = mk_tok(K_NUMBER, tline_q, tcol_q, cnt_q, R_NONE);
							n = n + 2'd1;
							toks[n] = mk_tok(K_ERROR, tline_q, dcol, 10'd1, R_UNEXP);
							n = n + 2'd1;
							nmode = M_IDLE;
							restart = 1'b1;
						end
					end
					M_IDENT: begin
						if (is_word(c) && cnt_q < 10'(IDENT_MAX_LEN)) begin
							nhits = kw_filter(hits_q, cnt_q, c);
							ncnt  = cnt_q + 10'd1;
						end else begin
							toks[n] = mk_tok(ident_kind(hits_q, cnt_q), tline_q, tcol_q,
								cnt_q, R_NONE);
							n = n + 2'd1;
							nmode = M_IDLE;
							restart = 1'b1;
						end
					end
					default: begin
						nmode = M_IDLE;
						restart = 1'b1;
					end
				endcase

				// Lex the byte afresh
				if (restart && !(c == " " || c == 8'h09 || c == 8'h0D)) begin
					if (c == 8'h0A) begin
						toks[n] = mk_tok(K_NEWLINE, line_q, col_q, 10'd1, R_NONE);
						n = n + 2'd1;
					end else begin
						ntline = line_q;
						ntcol  = col_q;
						if (c == "\"") begin
							nmode = M_STRING;
							ncnt  = 10'd0;
						end else if (is_digit(c)) begin
							nmode = M_NUMBER;
							ncnt  = 10'd1;
							ndot  = 1'b0;
						end else if (is_alpha(c) || c == "_") begin
							nmode = M_IDENT;
							nhits = kw_filter('1, 10'd0, c);
							ncnt  = 10'd1;
						end else if (c == "-" || c == "=" || c == "!" || c == "<" ||
								c == ">" || c == "/") begin
							nmode = M_HELD;
							nheld = c;
						end else begin
							k = single_kind(c);
							toks[n] = mk_tok(k, line_q, col_q, 10'd1,
								(k == K_ERROR) ? R_UNEXP : R_NONE);
							n = n + 2'd1;
						end
					end
				end

				// Advance line and column, saturating
				if (c == 8'h0A) begin
					if (line_q != '1) nline = line_q + 1'b1;
					ncol = COLUMN_BITS'(1);
				end else if (col_q != '1) begin
					ncol = col_q + 1'b1;
				end
			end
			if (n != 2'd0) toks[n - 2'd1].last_of_run = 1'b1;
		end
		run.toks  = toks;
		run.count = n;
	end

	// Hold scanner state between transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			held_q  <= '0;
			cnt_q   <= '0;
			dot_q   <= 1'b0;
			hits_q  <= '1;
			line_q  <= LINE_BITS'(1);
			col_q   <= COLUMN_BITS'(1);
			tline_q <= LINE_BITS'(1);
			tcol_q  <= COLUMN_BITS'(1);
			fin_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= nmode;
			held_q  <= nheld;
			cnt_q   <= ncnt;
			dot_q   <= ndot;
			hits_q  <= nhits;
			line_q  <= nline;
			col_q   <= ncol;
			tline_q <= ntline;
			tcol_q  <= ntcol;
			fin_q   <= nfin;
		end
	end

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q) else $error("finished flag cleared");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> mode_q == M_IDLE) else $error("scanner active after EOF");
	a_eot_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && din.end_of_text) |=> fin_q) else $error("end of text not latched");
	a_no_run_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> run.count == 2'd0) else $error("tokens after EOF");

endmodule

[rtl/core/stok_outbuf.sv]
// Three-entry result buffer that drains the tokens of one transfer.
module stok_outbuf import stok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_run_t  run,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output tok_item_t data
);

	tok_item_t [MAX_TOK-1:0] buf_q;
	logic [1:0]              cnt_q;
	logic                    pop;

	assign valid = cnt_q != 2'd0;
	assign pop   = valid && !stall;
	assign room  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign data  = buf_q[0];

	// Load a whole run or shift out the head
	always_ff @(posedge clk) begin
		if (push) buf_q <= run.toks;
		else if (pop) buf_q <= {buf_q[MAX_TOK-1], buf_q[MAX_TOK-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else if (push) cnt_q <= run.count;
		else if (pop) cnt_q <= cnt_q - 2'd1;
	end

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> buf_q[0].last_of_run) else $error("run tail lacks last flag");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room) else $error("run loaded over pending tokens");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && stall) |=> (valid && $stable(data))) else $error("stalled token changed");

endmodule

[rtl/core/source_tokenizer.sv]
// Top level of the streaming source tokenizer.
// Usage:
//   src channel: one source byte per transfer (src_valid/src_stall/src_data).
//   A zero byte or end_of_text ends the text: pending tokens, then EOF.
//   tok channel: one token per transfer (tok_valid/tok_stall/tok_data);
//   last_of_run marks the final token caused by one source byte.
// Output: a byte's first token shows the cycle after the byte is taken.
// Throughput: one byte per cycle while tok_stall is low and no byte
//   yields more than one token. A byte that yields two or three tokens
//   holds src_stall while the three-entry result buffer drains; the
//   buffer accepts a new byte in the cycle its last token is taken.
// Reset: the scanner returns to line 1, column 1 with no token pending and
//   the result buffer empties. After EOF, bytes are taken and dropped
//   until the next reset.
// Stall: while tok_stall is high the head token holds and src_stall rises
//   whenever the buffer holds a token that is not taken in that cycle.
module source_tokenizer import stok_pkg::*; #(
	parameter int IDENT_MAX_LEN  = IDENT_MAX_LEN_D,
	parameter int NUMBER_MAX_LEN = NUMBER_MAX_LEN_D,
	parameter int STRING_MAX_LEN = STRING_MAX_LEN_D,
	parameter int LINE_BITS      = LINE_BITS_D,
	parameter int COLUMN_BITS    = COLUMN_BITS_D
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok_data
);

	logic     accept;
	logic     room;
	tok_run_t run;

	assign src_stall = !room;
	assign accept    = src_valid && room;

	stok_lexer #(
		.IDENT_MAX_LEN (IDENT_MAX_LEN),
		.NUMBER_MAX_LEN(NUMBER_MAX_LEN),
		.STRING_MAX_LEN(STRING_MAX_LEN),
		.LINE_BITS     (LINE_BITS),
		.COLUMN_BITS   (COLUMN_BITS)
	) u_lexer (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.din   (src_data),
		.run   (run)
	);

	stok_outbuf u_outbuf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.run   (run),
		.room  (room),
		.valid (tok_valid),
		.stall (tok_stall),
		.data  (tok_data)
	);

endmodule
